@@ hdl/bpeh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpeh_pkg: shared types and constants for the bit position error histogram
// Command flags passed from the front end to the counter engine, the engine's
// state encoding and the fixed field widths of the ports.
// ----------------------------------------------------------------------------
package bpeh_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_IN_W    = 11;
  localparam int unsigned INDEX_IN_W  = 10;
  localparam int unsigned POS_OUT_W   = 10;
  localparam int unsigned COUNT_OUT_W = 32;
  localparam int unsigned RESTART_W   = 16;

  localparam logic [COUNT_OUT_W-1:0] THRESHOLD_RESET = 32'd100;

  typedef enum logic {
    OP_COMPARE = 1'b0,
    OP_READ    = 1'b1
  } op_t;

  typedef struct packed {
    logic is_read;
    logic bit_error;
    logic frame_done;
    logic restarted;
    logic first;
    logic zero_read;
  } cmd_flags_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CLEAR  = 4'b0010,
    S_READ   = 4'b0100,
    S_RESULT = 4'b1000
  } back_state_t;

endpackage

@@ hdl/bpeh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpeh_front: input classification and frame tracking
// Accepts transactions, clamps the frame length, tracks the bit position,
// frame length and restart count, and builds one command per transaction.
// ----------------------------------------------------------------------------
module bpeh_front #(
  parameter int MAX_POSITIONS = 1024,
  parameter int AW            = 10,
  parameter int LW            = 11
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic [bpeh_pkg::BYTE_W-1:0]           data_byte,
  input  logic [bpeh_pkg::BYTE_W-1:0]           ref_byte,
  input  logic [bpeh_pkg::LEN_IN_W-1:0]         frame_len,
  input  logic [bpeh_pkg::INDEX_IN_W-1:0]       read_index,
  input  logic                                  q_full,
  output logic                                  push,
  output bpeh_pkg::cmd_flags_t                  flags,
  output logic [AW-1:0]                         addr,
  output logic [AW-1:0]                         pos,
  output logic [LW-1:0]                         len,
  output logic [bpeh_pkg::RESTART_W-1:0]        rc
);
  import bpeh_pkg::*;

  logic [LW-1:0]        cur_len;
  logic [AW-1:0]        bit_pos;
  logic [RESTART_W-1:0] restarts;

  logic [LW-1:0]        eff_len;
  logic                 is_read;
  logic                 restart;
  logic [AW-1:0]        cnt_pos;
  logic [LW-1:0]        pos_inc;
  logic                 done;
  logic [RESTART_W-1:0] restarts_next;
  logic                 read_hit;

  always_comb begin
    // zero acts as one, anything past the counter array as the array size
    if (frame_len == '0) begin
      eff_len = LW'(1);
    end else if (32'(frame_len) > 32'(MAX_POSITIONS)) begin
      eff_len = LW'(MAX_POSITIONS);
    end else begin
      eff_len = LW'(frame_len);
    end
    is_read       = (op == OP_READ);
    restart       = !is_read && (eff_len != cur_len);
    cnt_pos       = restart ? '0 : bit_pos;
    pos_inc       = LW'(cnt_pos) + LW'(1);
    done          = !is_read && (pos_inc >= eff_len);
    restarts_next = (restart && cur_len != '0) ? restarts + RESTART_W'(1) : restarts;
    read_hit      = 32'(read_index) < 32'(cur_len);
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    flags.is_read    = is_read;
    flags.bit_error  = !is_read && (data_byte != ref_byte);
    flags.frame_done = done;
    flags.restarted  = restart;
    flags.first      = (cnt_pos == '0);
    flags.zero_read  = is_read && !read_hit;
    addr             = is_read ? AW'(read_index) : cnt_pos;
    pos              = is_read ? bit_pos : cnt_pos;
    len              = eff_len;
    rc               = restarts_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_len  <= '0;
      bit_pos  <= '0;
      restarts <= '0;
    end else if (push && !is_read) begin
      cur_len  <= eff_len;
      bit_pos  <= done ? '0 : AW'(pos_inc);
      restarts <= restarts_next;
    end
  end

endmodule

@@ hdl/bpeh_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpeh_queue: command queue between front end and counter engine
// Small register FIFO; lets either side stall without holding the other.
// ----------------------------------------------------------------------------
module bpeh_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);
  import bpeh_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [QW-1:0]    count;

  assign full  = (count == QW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + QW'(1);
      end else if (pop && !push) begin
        count <= count - QW'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

  a_fill_steps: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QW'(1))
    else $error("queue fill count did not advance on a push");

endmodule

@@ hdl/bpeh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpeh_back: counter engine
// Holds the per-position counter memory, clears it over the frame length on a
// restart, reads one counter per command and writes it back for a compare,
// keeps the running frame minimum and the sticky flag, registers the result.
// ----------------------------------------------------------------------------
module bpeh_back #(
  parameter int MAX_POSITIONS = 1024,
  parameter int CW            = 32,
  parameter int AW            = 10,
  parameter int LW            = 11
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  output logic                                 pop,
  input  bpeh_pkg::cmd_flags_t                 q_flags,
  input  logic [AW-1:0]                        q_addr,
  input  logic [AW-1:0]                        q_pos,
  input  logic [LW-1:0]                        q_len,
  input  logic [bpeh_pkg::RESTART_W-1:0]       q_rc,
  input  logic [bpeh_pkg::COUNT_OUT_W-1:0]     threshold,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bpeh_pkg::COUNT_OUT_W-1:0]     count_value,
  output logic [bpeh_pkg::POS_OUT_W-1:0]       position,
  output logic                                 bit_error,
  output logic                                 frame_done,
  output logic                                 min_reached,
  output logic                                 restarted,
  output logic [bpeh_pkg::RESTART_W-1:0]       restart_count
);
  import bpeh_pkg::*;

  logic [CW-1:0]        counters [MAX_POSITIONS];

  back_state_t          state;
  cmd_flags_t           cmd_flags;
  logic [AW-1:0]        cmd_addr;
  logic [AW-1:0]        cmd_pos;
  logic [LW-1:0]        cmd_len;
  logic [RESTART_W-1:0] cmd_rc;
  logic [AW-1:0]        clr_addr;
  logic [CW-1:0]        rd_data;
  logic [CW-1:0]        frame_min;
  logic                 min_flag;

  logic                 fire;
  logic                 clear_last;
  logic [CW-1:0]        new_cnt;
  logic [CW-1:0]        run_min;
  logic                 thr_met;
  logic                 flag_next;
  logic [CW-1:0]        result_cnt;
  logic [COUNT_OUT_W-1:0] count_out;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [CW-1:0]        wdata;
  logic                 re;
  logic [AW-1:0]        raddr;

  always_comb begin
    pop        = (state == S_IDLE) && q_valid;
    fire       = (state == S_RESULT) && (!out_valid || !out_stall);
    clear_last = (LW'(clr_addr) + LW'(1)) == cmd_len;
    // saturating increment
    new_cnt    = (cmd_flags.bit_error && rd_data != '1) ? rd_data + CW'(1) : rd_data;
    // every position is visited once per frame, so the minimum over the visits
    // equals the minimum over the frame's counters at frame end
    run_min    = (cmd_flags.first || new_cnt < frame_min) ? new_cnt : frame_min;
    thr_met    = 64'(run_min) >= 64'(threshold);
    flag_next  = (cmd_flags.restarted ? 1'b0 : min_flag) | (cmd_flags.frame_done && thr_met);
    if (cmd_flags.is_read) begin
      result_cnt = cmd_flags.zero_read ? '0 : rd_data;
    end else begin
      result_cnt = new_cnt;
    end
    count_out  = (CW > 32 && (64'(result_cnt) >> 32) != 64'd0) ? '1 : COUNT_OUT_W'(result_cnt);
    we         = (state == S_CLEAR) || (fire && !cmd_flags.is_read);
    waddr      = (state == S_CLEAR) ? clr_addr : cmd_addr;
    wdata      = (state == S_CLEAR) ? '0 : new_cnt;
    re         = pop || (state == S_READ);
    raddr      = pop ? q_addr : cmd_addr;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      counters[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= counters[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      min_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= q_flags.restarted ? S_CLEAR : S_RESULT;
          end
        end
        S_CLEAR: begin
          if (clear_last) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fire && !cmd_flags.is_read) begin
        min_flag <= flag_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_flags <= q_flags;
      cmd_addr  <= q_addr;
      cmd_pos   <= q_pos;
      cmd_len   <= q_len;
      cmd_rc    <= q_rc;
      clr_addr  <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
    if (fire && !cmd_flags.is_read) begin
      frame_min <= run_min;
    end
    if (fire) begin
      count_value   <= count_out;
      position      <= POS_OUT_W'(cmd_pos);
      bit_error     <= cmd_flags.bit_error;
      frame_done    <= cmd_flags.frame_done;
      min_reached   <= cmd_flags.is_read ? min_flag : flag_next;
      restarted     <= cmd_flags.restarted;
      restart_count <= cmd_rc;
    end
  end

  a_clear_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (LW'(clr_addr) < cmd_len))
    else $error("clearing walk ran past the frame length");

  a_read_after_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> cmd_flags.restarted)
    else $error("counter re-read without a preceding clear");

  a_result_from_engine: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(state == S_RESULT))
    else $error("result raised outside the result state");

  a_flag_drops_on_restart: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(min_flag)) |-> $past(fire && cmd_flags.restarted))
    else $error("sticky flag dropped without a restart");

endmodule

@@ hdl/bit_position_error_histogram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_position_error_histogram: per-position bit error counter
// Counts byte mismatches at each bit position of a frame, with saturating
// counters, a sticky minimum-reached flag and a length-change restart count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): op selects a compare or a counter
//   read. A transaction is taken when in_valid is high and in_stall is low.
//   Output channel (out_valid / out_stall): one result per input transaction,
//   in order; the result is held while out_stall is high.
//   Config channel (cfg_valid / cfg_ready): writes min_threshold; cfg_ready is
//   always high. Write it only while no transaction is in flight.
//   Each result passes through the command queue, the counter read and the
//   result register before out_valid rises. The engine finishes one
//   transaction, a counter read and for a compare its write, before it pops
//   the next. A compare that changes the frame length first walks the counter
//   memory over the frame length to zero it; the first compare after reset does this too.
//   A two-entry command queue keeps taking input while the output stalls;
//   in_stall rises once it is full.
//   Reset: clears position, length, flag, restart count and threshold (100);
//   the counter memory needs no clearing pass, reads past the length give 0.
// ----------------------------------------------------------------------------
module bit_position_error_histogram #(
  parameter int MAX_POSITIONS = 1024,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic [bpeh_pkg::BYTE_W-1:0]          data_byte,
  input  logic [bpeh_pkg::BYTE_W-1:0]          ref_byte,
  input  logic [bpeh_pkg::LEN_IN_W-1:0]        frame_len,
  input  logic [bpeh_pkg::INDEX_IN_W-1:0]      read_index,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bpeh_pkg::COUNT_OUT_W-1:0]     count_value,
  output logic [bpeh_pkg::POS_OUT_W-1:0]       position,
  output logic                                 bit_error,
  output logic                                 frame_done,
  output logic                                 min_reached,
  output logic                                 restarted,
  output logic [bpeh_pkg::RESTART_W-1:0]       restart_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bpeh_pkg::COUNT_OUT_W-1:0]     min_threshold
);
  import bpeh_pkg::*;

  localparam int AW = $clog2(MAX_POSITIONS);
  localparam int LW = $clog2(MAX_POSITIONS + 1);
  localparam int QW = $bits(cmd_flags_t) + 2 * AW + LW + RESTART_W;

  logic [COUNT_OUT_W-1:0] threshold;

  logic                 push;
  logic                 q_full;
  cmd_flags_t           f_flags;
  logic [AW-1:0]        f_addr;
  logic [AW-1:0]        f_pos;
  logic [LW-1:0]        f_len;
  logic [RESTART_W-1:0] f_rc;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;
  logic                 q_valid;
  logic                 pop;
  cmd_flags_t           q_flags;
  logic [AW-1:0]        q_addr;
  logic [AW-1:0]        q_pos;
  logic [LW-1:0]        q_len;
  logic [RESTART_W-1:0] q_rc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= min_threshold;
    end
  end

  bpeh_front #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .AW            (AW),
    .LW            (LW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .data_byte  (data_byte),
    .ref_byte   (ref_byte),
    .frame_len  (frame_len),
    .read_index (read_index),
    .q_full     (q_full),
    .push       (push),
    .flags      (f_flags),
    .addr       (f_addr),
    .pos        (f_pos),
    .len        (f_len),
    .rc         (f_rc)
  );

  assign q_wdata = {f_flags, f_addr, f_pos, f_len, f_rc};
  assign {q_flags, q_addr, q_pos, q_len, q_rc} = q_rdata;

  bpeh_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  bpeh_back #(
    .MAX_POSITIONS (MAX_POSITIONS),
    .CW            (COUNT_WIDTH),
    .AW            (AW),
    .LW            (LW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .pop           (pop),
    .q_flags       (q_flags),
    .q_addr        (q_addr),
    .q_pos         (q_pos),
    .q_len         (q_len),
    .q_rc          (q_rc),
    .threshold     (threshold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .count_value   (count_value),
    .position      (position),
    .bit_error     (bit_error),
    .frame_done    (frame_done),
    .min_reached   (min_reached),
    .restarted     (restarted),
    .restart_count (restart_count)
  );

endmodule
